/* hdl/apr_pkg.sv */
// Package: widths, Q7.16 constants, register indexes and shared types of the offset regulator.
package apr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 24;

    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int GX_W      = GAIN_W + 1;
    localparam int LIM_W     = DATA_WIDTH - 1;
    localparam int VAR_W     = 2 * FRAC_BITS;
    localparam int MA_W      = DATA_WIDTH + 2;
    localparam int MB_W      = VAR_W + 2;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = LIM_W;
    localparam int INIT_I_W  = 14;
    localparam int INIT_D_W  = 16;

    localparam int K_ONE     = 1 << FRAC_BITS;
    localparam int K_ALPHA   = (K_ONE + 10) / 20;
    localparam int K_TENTH   = (K_ONE + 5) / 10;
    localparam int K_HALF    = (K_ONE + 1) / 2;
    localparam int K_FIFTH   = (K_ONE + 2) / 5;
    localparam int K_STEP_PD = (K_ONE + 100) / 200;
    localparam int K_STEP_I  = (K_ONE + 500) / 1000;
    localparam int K_DECAY   = (K_ONE * 199 + 100) / 200;
    localparam int K_GP_MIN  = K_ALPHA;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_LIM  = 3'd6;

    localparam logic [GAIN_W-1:0] RST_GAIN_P   = GAIN_W'(19661);
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = GAIN_W'(3277);
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = GAIN_W'(6554);
    localparam logic [LIM_W-1:0]  RST_OUT_LIM  = LIM_W'(327680);
    localparam logic [LIM_W-1:0]  RST_DEADBAND = LIM_W'(13107);
    localparam logic [LIM_W-1:0]  RST_MAX_STEP = LIM_W'(13107);
    localparam logic [LIM_W-1:0]  RST_OFS_LIM  = LIM_W'(65536);

    localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] VAR_MAX_P =
        {{(PROD_W - VAR_W){1'b0}}, {VAR_W{1'b1}}};

    typedef struct packed {
        logic [LIM_W-1:0] out_limit;
        logic [LIM_W-1:0] dead_band;
        logic [LIM_W-1:0] max_step;
        logic [LIM_W-1:0] offset_limit;
    } t_lim_cfg;

    typedef struct packed {
        logic              ld_p;
        logic              ld_i;
        logic              ld_d;
        logic [GAIN_W-1:0] value;
    } t_gain_wr;

    function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] x);
        return (x + RND_HALF) >>> FRAC_BITS;
    endfunction

endpackage

/* hdl/adaptive_pid_offset_regulator.sv */
// Top level: configuration registers, input/output handshake and result register.
// An input is taken only in idle; o_in_stall stays high until the result has been passed to the
// output register, so one item is processed at a time. The single shared multiplier and its
// sequencer carry the mean, square, variance, gain decay and three PID products in turn.
// Reset (synchronous, active low) restores register defaults, loads the gains from
// them and clears the integral, statistics, previous error and previous offset.
module adaptive_pid_offset_regulator import apr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_error_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_offset_out,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DAT_W-1:0]         i_cfg_data
);

    t_lim_cfg                     r_cfg;
    t_gain_wr                     gain_wr;
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_offset;
    logic                         out_free, res_valid, busy;
    logic signed [DATA_WIDTH-1:0] res_data;

    always_comb begin
        gain_wr.ld_p  = i_cfg_wr_en && (i_cfg_index == REG_INIT_P);
        gain_wr.ld_i  = i_cfg_wr_en && (i_cfg_index == REG_INIT_I);
        gain_wr.ld_d  = i_cfg_wr_en && (i_cfg_index == REG_INIT_D);
        gain_wr.value = i_cfg_data[GAIN_W-1:0];
        unique case (i_cfg_index)
            REG_INIT_I: gain_wr.value = GAIN_W'(i_cfg_data[INIT_I_W-1:0]);
            REG_INIT_D: gain_wr.value = GAIN_W'(i_cfg_data[INIT_D_W-1:0]);
            default:    gain_wr.value = i_cfg_data[GAIN_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_limit    <= RST_OUT_LIM;
            r_cfg.dead_band    <= RST_DEADBAND;
            r_cfg.max_step     <= RST_MAX_STEP;
            r_cfg.offset_limit <= RST_OFS_LIM;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_OUT_LIM:  r_cfg.out_limit    <= i_cfg_data;
                REG_DEADBAND: r_cfg.dead_band    <= i_cfg_data;
                REG_MAX_STEP: r_cfg.max_step     <= i_cfg_data;
                REG_OFS_LIM:  r_cfg.offset_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    apr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_error_value (i_error_value),
        .o_busy        (busy),
        .i_cfg         (r_cfg),
        .i_gain_wr     (gain_wr),
        .i_out_free    (out_free),
        .o_res_valid   (res_valid),
        .o_res_data    (res_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_offset <= res_data;
        end
    end

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_offset_out = r_offset;

endmodule

/* hdl/apr_mul.sv */
// Shared signed multiplier with registered product.
module apr_mul import apr_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hdl/apr_core.sv */
// Sequencer and datapath: deadband, statistics, gain adaptation, PID sum, saturation, rate limit and clamp.
module apr_core import apr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic signed [DATA_WIDTH-1:0] i_error_value,
    output logic                         o_busy,
    input  t_lim_cfg                     i_cfg,
    input  t_gain_wr                     i_gain_wr,
    input  logic                         i_out_free,
    output logic                         o_res_valid,
    output logic signed [DATA_WIDTH-1:0] o_res_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_DBAND, S_MUL_MEAN, S_UPD_MEAN, S_MUL_SQ, S_UPD_SQ, S_MUL_VAR,
        S_UPD_VAR, S_ADAPT, S_MUL_GP, S_UPD_GP, S_CLAMP, S_MUL_P, S_MUL_I,
        S_MUL_D, S_ACC_D, S_SAT, S_RATE, S_EMIT
    } t_state;

    t_state                      r_state;
    logic signed [DATA_WIDTH-1:0] r_e, r_mean, r_int, r_le, r_lo, r_y;
    logic [VAR_W-1:0]            r_var, r_sq;
    logic [GAIN_W-1:0]           r_gp, r_gi, r_gd;
    logic [GX_W-1:0]             r_gp_t, r_gi_t, r_gd_t;
    logic signed [PROD_W-1:0]    r_acc;

    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]    mul_p, rnd_p, var_sum, acc_rnd, lim_p;
    logic signed [MA_W-1:0]      e_w, mean_w, le_w, int_w, y_w, lo_w, diff_me, delta;
    logic signed [MA_W-1:0]      abs_e, abs_mean, lim_w, step_w, olim_w, int_sum, y_lim;
    logic                        c_steady, c_bias, c_osc;

    apr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        e_w      = MA_W'(r_e);
        mean_w   = MA_W'(r_mean);
        le_w     = MA_W'(r_le);
        int_w    = MA_W'(r_int);
        y_w      = MA_W'(r_y);
        lo_w     = MA_W'(r_lo);
        lim_w    = $signed({{(MA_W - LIM_W){1'b0}}, i_cfg.out_limit});
        step_w   = $signed({{(MA_W - LIM_W){1'b0}}, i_cfg.max_step});
        olim_w   = $signed({{(MA_W - LIM_W){1'b0}}, i_cfg.offset_limit});
        lim_p    = $signed({{(PROD_W - LIM_W){1'b0}}, i_cfg.out_limit});
        diff_me  = e_w - mean_w;
        abs_e    = e_w[MA_W-1] ? -e_w : e_w;
        abs_mean = mean_w[MA_W-1] ? -mean_w : mean_w;
        int_sum  = int_w + e_w;
        delta    = y_w - lo_w;
        rnd_p    = rnd_q(mul_p);
        acc_rnd  = rnd_q(r_acc);
        var_sum  = $signed({{(PROD_W - VAR_W){1'b0}}, r_var}) + rnd_p;
        c_steady = (abs_e > MA_W'(K_ONE)) && (r_var < VAR_W'(K_TENTH));
        c_bias   = abs_mean > MA_W'(K_HALF);
        c_osc    = r_var > VAR_W'(K_HALF);

        if (delta > step_w) begin
            y_lim = lo_w + step_w;
        end else if (delta < -step_w) begin
            y_lim = lo_w - step_w;
        end else begin
            y_lim = y_w;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_MEAN: begin
                mul_a = diff_me;
                mul_b = MB_W'(K_ALPHA);
            end
            S_MUL_SQ: begin
                mul_a = diff_me;
                mul_b = MB_W'(diff_me);
            end
            S_MUL_VAR: begin
                mul_a = MA_W'(K_ALPHA);
                mul_b = $signed({2'b00, r_sq}) - $signed({2'b00, r_var});
            end
            S_MUL_GP: begin
                mul_a = $signed({{(MA_W - GX_W){1'b0}}, r_gp_t});
                mul_b = MB_W'(K_DECAY);
            end
            S_MUL_P: begin
                mul_a = $signed({{(MA_W - GAIN_W){1'b0}}, r_gp});
                mul_b = MB_W'(e_w);
            end
            S_MUL_I: begin
                mul_a = $signed({{(MA_W - GAIN_W){1'b0}}, r_gi});
                mul_b = MB_W'(int_w);
            end
            S_MUL_D: begin
                mul_a = $signed({{(MA_W - GAIN_W){1'b0}}, r_gd});
                mul_b = MB_W'(e_w - le_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (y_w > olim_w) begin
            o_res_data = DATA_WIDTH'(olim_w);
        end else if (y_w < -olim_w) begin
            o_res_data = DATA_WIDTH'(-olim_w);
        end else begin
            o_res_data = r_y;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mean  <= '0;
            r_var   <= '0;
            r_int   <= '0;
            r_le    <= '0;
            r_lo    <= '0;
            r_gp    <= RST_GAIN_P;
            r_gi    <= RST_GAIN_I;
            r_gd    <= RST_GAIN_D;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_e     <= i_error_value;
                        r_state <= S_DBAND;
                    end
                end
                S_DBAND: begin
                    if (abs_e < $signed({{(MA_W - LIM_W){1'b0}}, i_cfg.dead_band})) begin
                        r_e <= '0;
                    end
                    r_state <= S_MUL_MEAN;
                end
                S_MUL_MEAN: r_state <= S_UPD_MEAN;
                S_UPD_MEAN: begin
                    r_mean  <= r_mean + rnd_p[DATA_WIDTH-1:0];
                    r_state <= S_MUL_SQ;
                end
                S_MUL_SQ: r_state <= S_UPD_SQ;
                S_UPD_SQ: begin
                    r_sq    <= (rnd_p > VAR_MAX_P) ? {VAR_W{1'b1}} : rnd_p[VAR_W-1:0];
                    r_state <= S_MUL_VAR;
                end
                S_MUL_VAR: r_state <= S_UPD_VAR;
                S_UPD_VAR: begin
                    if (var_sum < 0) begin
                        r_var <= '0;
                    end else if (var_sum > VAR_MAX_P) begin
                        r_var <= {VAR_W{1'b1}};
                    end else begin
                        r_var <= var_sum[VAR_W-1:0];
                    end
                    r_state <= S_ADAPT;
                end
                S_ADAPT: begin
                    r_gp_t  <= GX_W'(r_gp) + (c_steady ? GX_W'(K_STEP_PD) : '0);
                    r_gi_t  <= GX_W'(r_gi) + (c_bias ? GX_W'(K_STEP_I) : '0);
                    r_gd_t  <= GX_W'(r_gd) + (c_osc ? GX_W'(K_STEP_PD) : '0);
                    r_state <= c_osc ? S_MUL_GP : S_CLAMP;
                end
                S_MUL_GP: r_state <= S_UPD_GP;
                S_UPD_GP: begin
                    r_gp_t  <= rnd_p[GX_W-1:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_gp_t < GX_W'(K_GP_MIN)) begin
                        r_gp <= GAIN_W'(K_GP_MIN);
                    end else if (r_gp_t > GX_W'(K_ONE)) begin
                        r_gp <= GAIN_W'(K_ONE);
                    end else begin
                        r_gp <= r_gp_t[GAIN_W-1:0];
                    end
                    r_gi <= (r_gi_t > GX_W'(K_FIFTH)) ? GAIN_W'(K_FIFTH) : r_gi_t[GAIN_W-1:0];
                    r_gd <= (r_gd_t > GX_W'(K_HALF)) ? GAIN_W'(K_HALF) : r_gd_t[GAIN_W-1:0];
                    if (int_sum > lim_w) begin
                        r_int <= DATA_WIDTH'(lim_w);
                    end else if (int_sum < -lim_w) begin
                        r_int <= DATA_WIDTH'(-lim_w);
                    end else begin
                        r_int <= DATA_WIDTH'(int_sum);
                    end
                    r_state <= S_MUL_P;
                end
                S_MUL_P: r_state <= S_MUL_I;
                S_MUL_I: begin
                    r_acc   <= mul_p;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_acc   <= r_acc + mul_p;
                    r_state <= S_ACC_D;
                end
                S_ACC_D: begin
                    r_acc   <= r_acc + mul_p;
                    r_le    <= r_e;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (acc_rnd > lim_p) begin
                        r_y <= DATA_WIDTH'(lim_p);
                    end else if (acc_rnd < -lim_p) begin
                        r_y <= DATA_WIDTH'(-lim_p);
                    end else begin
                        r_y <= acc_rnd[DATA_WIDTH-1:0];
                    end
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_y     <= DATA_WIDTH'(y_lim);
                    r_lo    <= DATA_WIDTH'(y_lim);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_gain_wr.ld_p) begin
                r_gp <= i_gain_wr.value;
            end
            if (i_gain_wr.ld_i) begin
                r_gi <= i_gain_wr.value;
            end
            if (i_gain_wr.ld_d) begin
                r_gd <= i_gain_wr.value;
            end
        end
    end

endmodule
